[hdl/kpnk_pkg.sv]
`default_nettype none

package kpnk_pkg;

  // Pool geometry.
  localparam int unsigned POOL_DEPTH = 1024;
  localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W      = $clog2(POOL_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUP       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] entry_id;
    logic signed [15:0] group_number;
    logic signed [31:0] score;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic signed [31:0] found_id;
    logic signed [15:0] found_group;
    logic signed [31:0] found_score;
  } res_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             scan_init;
    logic             rd_en;
    logic             clr_we;
    logic             commit;
    logic [IDX_W-1:0] addr;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

[hdl/kpnk_ctrl.sv]
`default_nettype none

module kpnk_ctrl
  import kpnk_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  output ctrl_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  localparam logic [IDX_W-1:0] LastAddr = IDX_W'(POOL_DEPTH - 1);

  state_e           state_q;
  logic [IDX_W-1:0] addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (addr_q == LastAddr) begin
            state_q <= S_IDLE;
            addr_q  <= '0;
          end else begin
            addr_q <= addr_q + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            state_q <= S_SCAN;
            addr_q  <= '0;
          end
        end
        S_SCAN: begin
          if (addr_q == LastAddr) begin
            state_q <= S_DRAIN;
            addr_q  <= '0;
          end else begin
            addr_q <= addr_q + IDX_W'(1);
          end
        end
        S_DRAIN:  state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.addr      = addr_q;
    cmd_o.capture   = (state_q == S_IDLE) && start;
    cmd_o.scan_init = (state_q == S_IDLE) && start;
    cmd_o.rd_en     = (state_q == S_SCAN);
    cmd_o.clr_we    = (state_q == S_CLEAR);
    cmd_o.commit    = (state_q == S_COMMIT);
  end

endmodule

`default_nettype wire

[hdl/kpnk_dp.sv]
`default_nettype none

module kpnk_dp
  import kpnk_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  input  wire in_item_t  item_i,
  output res_item_t      result_o,
  output logic           result_valid_o
);

  typedef struct packed {
    logic               valid;
    logic signed [31:0] id;
    logic signed [15:0] grp;
    logic signed [31:0] score;
    logic [31:0]        age;
  } slot_t;

  slot_t mem_q [POOL_DEPTH];

  in_item_t         in_q;
  slot_t            rd_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_vld_q;

  // Scan trackers.
  logic               hit_q, hit_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic               free_q, free_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic               best_vld_q, best_vld_d;
  logic signed [31:0] best_score_q, best_score_d;
  logic [31:0]        best_age_q, best_age_d;
  logic signed [31:0] best_id_q, best_id_d;
  logic signed [15:0] best_grp_q, best_grp_d;

  logic [CNT_W-1:0] live_q, live_d;
  logic [31:0]      ins_q, ins_d;

  res_item_t res_q, res_d;
  logic      res_vld_q;

  logic             we;
  logic [IDX_W-1:0] waddr;
  slot_t            wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q     <= mem_q[cmd_i.addr];
      rd_idx_q <= cmd_i.addr;
    end
    if (cmd_i.capture) begin
      in_q <= item_i;
    end
  end

  // Fold one slot into the running hit, free and best records.
  always_comb begin
    logic qualifies;
    logic better;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    best_vld_d   = best_vld_q;
    best_score_d = best_score_q;
    best_age_d   = best_age_q;
    best_id_d    = best_id_q;
    best_grp_d   = best_grp_q;
    qualifies    = (rd_q.score >= in_q.score);
    better       = !best_vld_q || (rd_q.score < best_score_q) ||
                   ((rd_q.score == best_score_q) && (rd_q.age < best_age_q));
    if (cmd_i.scan_init) begin
      hit_d      = 1'b0;
      free_d     = 1'b0;
      best_vld_d = 1'b0;
    end else if (rd_vld_q) begin
      if (rd_q.valid) begin
        if (!hit_q && (rd_q.id == in_q.entry_id)) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx_q;
        end
        if (qualifies && better) begin
          best_vld_d   = 1'b1;
          best_score_d = rd_q.score;
          best_age_d   = rd_q.age;
          best_id_d    = rd_q.id;
          best_grp_d   = rd_q.grp;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd_idx_q;
      end
    end
  end

  // Outcome of the finished scan, the pool update and the result item.
  always_comb begin
    we     = cmd_i.clr_we;
    waddr  = cmd_i.addr;
    wdata  = '0;
    live_d = live_q;
    ins_d  = ins_q;
    res_d  = '0;
    if (cmd_i.commit) begin
      case (in_q.command)
        CMD_ADD: begin
          if (hit_q) begin
            res_d.status = ST_DUP;
          end else if (live_q == CNT_W'(POOL_DEPTH)) begin
            res_d.status = ST_FULL;
          end else begin
            we          = 1'b1;
            waddr       = free_idx_q;
            wdata.valid = 1'b1;
            wdata.id    = in_q.entry_id;
            wdata.grp   = in_q.group_number;
            wdata.score = in_q.score;
            wdata.age   = ins_q;
            ins_d       = ins_q + 32'd1;
            live_d      = live_q + CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (hit_q) begin
            we    = 1'b1;
            waddr = hit_idx_q;
            if (live_q != '0) begin
              live_d = live_q - CNT_W'(1);
            end
          end
        end
        CMD_FIND: begin
          if (best_vld_q && (best_score_q > 32'sd0)) begin
            res_d.found       = 1'b1;
            res_d.found_id    = best_id_q;
            res_d.found_group = best_grp_q;
            res_d.found_score = best_score_q;
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end
        default: res_d.status = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q    <= hit_idx_d;
    free_idx_q   <= free_idx_d;
    best_score_q <= best_score_d;
    best_age_q   <= best_age_d;
    best_id_q    <= best_id_d;
    best_grp_q   <= best_grp_d;
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      best_vld_q <= 1'b0;
      live_q     <= '0;
      ins_q      <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.rd_en;
      hit_q      <= hit_d;
      free_q     <= free_d;
      best_vld_q <= best_vld_d;
      live_q     <= live_d;
      ins_q      <= ins_d;
      res_vld_q  <= cmd_i.commit;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

endmodule

`default_nettype wire

[hdl/keyed_pool_nearest_key_lookup_top.sv]
`default_nettype none

// Keyed pool with nearest-score lookup. The pool holds up to POOL_DEPTH entries
// in one on-chip memory; add, remove and find each walk the whole memory once,
// one entry per cycle through its single read port, with busy high from the
// time start is taken until the walk, the drain and the commit are done. The
// result item shows on result_o with result_valid_o high for exactly one cycle,
// in the cycle in which busy falls. A new item is taken only once busy is low.
// The receiver cannot stall the block and must take each result item in the
// cycle it appears. After reset the block clears the valid flags in the memory,
// with busy high, before it takes its first item.

module keyed_pool_nearest_key_lookup_top
  import kpnk_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t item_i,
  output res_item_t     result_o,
  output logic          result_valid_o
);

  // The controller sequences the clearing pass, the scan over every slot and
  // the commit cycle; it never looks at payload data.
  ctrl_cmd_t cmd;

  kpnk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // The datapath owns the pool memory. During the scan it records the first
  // slot holding the requested identifier, the lowest free slot, and the best
  // find candidate: the least score at or above the query, with the older
  // entry winning a tie. In the commit cycle it writes the pool at most once (a
  // new entry for an add, a cleared slot for a remove) and registers the result.
  kpnk_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire
